>>> hw/rtl/m2sh_pkg.sv
// Shared types and constants for the MPEG-2 sequence header extractor.
// No dependencies; imported by m2sh_parser and the top level.
`default_nettype none

package m2sh_pkg;

  // Start codes of the headers in the chain.
  localparam logic [31:0] SEQ_CODE = 32'h0000_01b3;
  localparam logic [31:0] EXT_CODE = 32'h0000_01b5;
  localparam logic [31:0] GOP_CODE = 32'h0000_01b8;

  // Section lengths in bytes.
  localparam logic [7:0] SEQ_LEN    = 8'd12;
  localparam logic [7:0] MATRIX_LEN = 8'd64;
  localparam logic [7:0] EXT_LEN    = 8'd10;
  localparam logic [7:0] DISP_LEN   = 8'd12;
  localparam logic [7:0] GOP_LEN    = 8'd8;
  localparam logic [7:0] PROBE_LEN  = 8'd4;

  // Matrix flag bits in the byte that closes a section.
  localparam logic [7:0] INTRA_FLAG    = 8'h02;
  localparam logic [7:0] NONINTRA_FLAG = 8'h01;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_KEY     = 3'd1;
  localparam logic [2:0] ST_NO_SEQ      = 3'd2;
  localparam logic [2:0] ST_NO_INTRA    = 3'd3;
  localparam logic [2:0] ST_NO_NONINTRA = 3'd4;
  localparam logic [2:0] ST_NO_EXT      = 3'd5;
  localparam logic [2:0] ST_NO_DISP     = 3'd6;
  localparam logic [2:0] ST_NO_GOP      = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       key_frame;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] header_len;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/m2sh_parser.sv
// Header chain parser: holds the per-packet parse state and steps it by one byte.
// Depends on m2sh_pkg.
`default_nettype none

module m2sh_parser
  import m2sh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire item_t   item,
  output logic         res_valid,
  output result_t      res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SEQ,
    PH_INTRA,
    PH_NONINTRA,
    PH_EXT,
    PH_PROBE,
    PH_DISP,
    PH_GOP,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  section_end, section_end_next;
  logic [31:0] code_window, code_window_next;
  logic [2:0]  pending_status, pending_status_next;

  logic [8:0]  idx_wide;
  logic [8:0]  end_wide;
  logic        at_end;
  logic        at_ext_code;
  logic        at_gop_code;
  logic [2:0]  st;

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    section_end_next    = section_end;
    code_window_next    = code_window;
    pending_status_next = pending_status;

    // First byte of a packet: sample the key flag.
    if (phase == PH_IDLE) begin
      byte_index_next  = '0;
      code_window_next = '0;
      if (item.key_frame) begin
        phase_next       = PH_SEQ;
        section_end_next = SEQ_LEN;
      end else begin
        phase_next          = PH_DONE;
        pending_status_next = ST_NOT_KEY;
        section_end_next    = '0;
      end
    end

    code_window_next = {code_window_next[23:0], item.data_byte};

    idx_wide    = {1'b0, byte_index_next};
    end_wide    = {1'b0, section_end_next};
    at_end      = (idx_wide + 9'd1) == end_wide;
    at_ext_code = (idx_wide + {1'b0, EXT_LEN} - 9'd3) == end_wide;
    at_gop_code = (idx_wide + {1'b0, GOP_LEN} - 9'd3) == end_wide;

    unique case (phase_next)
      PH_SEQ: begin
        if (byte_index_next == 8'd3 && code_window_next != SEQ_CODE) begin
          phase_next          = PH_DONE;
          pending_status_next = ST_NO_SEQ;
          section_end_next    = '0;
        end else if (byte_index_next == SEQ_LEN - 8'd1) begin
          if ((item.data_byte & INTRA_FLAG) != 8'd0) begin
            phase_next       = PH_INTRA;
            section_end_next = SEQ_LEN + MATRIX_LEN;
          end else if ((item.data_byte & NONINTRA_FLAG) != 8'd0) begin
            phase_next       = PH_NONINTRA;
            section_end_next = SEQ_LEN + MATRIX_LEN;
          end else begin
            phase_next       = PH_EXT;
            section_end_next = SEQ_LEN + EXT_LEN;
          end
        end
      end
      PH_INTRA: begin
        if (at_end) begin
          if ((item.data_byte & NONINTRA_FLAG) != 8'd0) begin
            phase_next       = PH_NONINTRA;
            section_end_next = section_end_next + MATRIX_LEN;
          end else begin
            phase_next       = PH_EXT;
            section_end_next = section_end_next + EXT_LEN;
          end
        end
      end
      PH_NONINTRA: begin
        if (at_end) begin
          phase_next       = PH_EXT;
          section_end_next = section_end_next + EXT_LEN;
        end
      end
      PH_EXT: begin
        if (at_ext_code && code_window_next != EXT_CODE) begin
          phase_next          = PH_DONE;
          pending_status_next = ST_NO_EXT;
          section_end_next    = '0;
        end else if (at_end) begin
          phase_next       = PH_PROBE;
          section_end_next = section_end_next + PROBE_LEN;
        end
      end
      PH_PROBE: begin
        // Four bytes tell whether a display extension or the GOP header follows.
        if (at_end) begin
          if (code_window_next == EXT_CODE) begin
            phase_next       = PH_DISP;
            section_end_next = section_end_next + DISP_LEN - PROBE_LEN;
          end else if (code_window_next == GOP_CODE) begin
            phase_next       = PH_GOP;
            section_end_next = section_end_next + GOP_LEN - PROBE_LEN;
          end else begin
            phase_next          = PH_DONE;
            pending_status_next = ST_NO_GOP;
            section_end_next    = '0;
          end
        end
      end
      PH_DISP: begin
        if (at_end) begin
          phase_next       = PH_GOP;
          section_end_next = section_end_next + GOP_LEN;
        end
      end
      PH_GOP: begin
        if (at_gop_code && code_window_next != GOP_CODE) begin
          phase_next          = PH_DONE;
          pending_status_next = ST_NO_GOP;
          section_end_next    = '0;
        end else if (at_end) begin
          // Section end now equals the total header length.
          phase_next          = PH_DONE;
          pending_status_next = ST_OK;
        end
      end
      default: begin
      end
    endcase

    unique case (phase_next)
      PH_DONE:     st = pending_status_next;
      PH_SEQ:      st = ST_NO_SEQ;
      PH_INTRA:    st = ST_NO_INTRA;
      PH_NONINTRA: st = ST_NO_NONINTRA;
      PH_EXT:      st = ST_NO_EXT;
      PH_DISP:     st = ST_NO_DISP;
      default:     st = ST_NO_GOP;
    endcase

    res.status     = st;
    res.header_len = (st == ST_OK) ? section_end_next : 8'd0;
    res_valid      = step && item.last_byte;

    if (item.last_byte) begin
      phase_next          = PH_IDLE;
      byte_index_next     = '0;
      section_end_next    = '0;
      code_window_next    = '0;
      pending_status_next = ST_OK;
    end else if (byte_index_next != 8'hff) begin
      byte_index_next = byte_index_next + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_index     <= '0;
      section_end    <= '0;
      code_window    <= '0;
      pending_status <= ST_OK;
    end else if (step) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      section_end    <= section_end_next;
      code_window    <= code_window_next;
      pending_status <= pending_status_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mpeg2_sequence_header_extractor.sv
// Top level of the MPEG-2 sequence header extractor: input register, parser, result register.
// Depends on m2sh_pkg and m2sh_parser.
`default_nettype none

// Channel   Direction  Contents
// s_axis    in         one packet byte per transaction; tuser = key flag, tlast = final byte
// m_axis    out        one status transaction per packet, issued for its final byte
//
// Each byte is held in the input register and then takes one step of the parser,
// whose state update is a byte compare and a short add. The result of a packet
// is registered when the parser steps on its final byte, then shown on m_axis.
// Sustained rate is one byte per cycle while the output accepts every result.
// Reset clears the parse state and both valid flags. A stalled output
// keeps a final byte waiting in the input register, and the input stalls
// behind it; bytes that end no packet step through even while the output is full.

module mpeg2_sequence_header_extractor
  import m2sh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] key_frame
  input  wire logic        s_axis_tlast,   // last_byte

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [2:0] status, [10:3] header_len, [15:11] zero
);

  // Input register stage.
  logic    in_valid;
  item_t   in_item;

  // Output register stage.
  logic    out_valid;
  result_t out_res;

  logic    step;
  logic    res_valid;
  result_t res;

  // A byte that produces a result may step only when the output slot is free
  // or is emptied in this same cycle.
  assign step = in_valid &&
                (!in_item.last_byte || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.data_byte <= s_axis_tdata;
      in_item.key_frame <= s_axis_tuser;
      in_item.last_byte <= s_axis_tlast;
    end
  end

  m2sh_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.header_len, out_res.status};

endmodule

`default_nettype wire
